// ===== rtl/core/sad_pkg.sv =====
// Shared constants, types and arctangent table for the segment angle pipeline.
`default_nettype none
package sad_pkg;

	localparam int CORDIC_STEPS    = 16;
	localparam int ANGLE_FRAC_BITS = 8;

	localparam int GUARD_BITS = 24;
	localparam int TABLE_FRAC = 20;
	localparam int TABLE_LEN  = 24;
	localparam int NUM_STEPS  = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

	localparam int COORD_W    = 16;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int XY_W       = DIFF_W + GUARD_BITS + 3;
	localparam int Z_W        = 29;
	localparam int ANGLE_W    = 18;
	localparam int IN_DATA_W  = 4 * COORD_W;
	localparam int OUT_DATA_W = ((ANGLE_W + 7) / 8) * 8;

	localparam int RND_SH = TABLE_FRAC - ANGLE_FRAC_BITS;
	localparam int BASE_W = ANGLE_FRAC_BITS + 7;
	localparam int CALC_W = (ANGLE_FRAC_BITS + 10 > ANGLE_W) ? ANGLE_FRAC_BITS + 10 : ANGLE_W;

	localparam logic signed [Z_W-1:0]    Z_FULL     = Z_W'(90 * (1 << TABLE_FRAC));
	localparam logic signed [Z_W-1:0]    ROUND_HALF = Z_W'(1 << (RND_SH - 1));
	localparam logic [BASE_W-1:0]        BASE_RIGHT = BASE_W'(90 * (1 << ANGLE_FRAC_BITS));
	localparam logic signed [CALC_W-1:0] HALF_TURN  = CALC_W'(180 * (1 << ANGLE_FRAC_BITS));

	// atan(2^-i) in degrees, Q.20
	localparam logic signed [Z_W-1:0] ATAN_Q20 [TABLE_LEN] = '{
		Z_W'(47185920), Z_W'(27855475), Z_W'(14718068), Z_W'(7471121),
		Z_W'(3750058),  Z_W'(1876857),  Z_W'(938658),   Z_W'(469357),
		Z_W'(234682),   Z_W'(117342),   Z_W'(58671),    Z_W'(29335),
		Z_W'(14668),    Z_W'(7334),     Z_W'(3667),     Z_W'(1833),
		Z_W'(917),      Z_W'(458),      Z_W'(229),      Z_W'(115),
		Z_W'(57),       Z_W'(29),       Z_W'(14),       Z_W'(7)
	};

	typedef struct packed {
		logic lt_x;
		logic gt_y;
		logic dx_zero;
		logic dy_zero;
	} flags_t;

	typedef struct packed {
		logic                   valid;
		flags_t                 flags;
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} cordic_t;

endpackage
`default_nettype wire

// ===== rtl/core/segment_angle_degrees.sv =====
// Top level: direction angle of a screen segment in degrees, fully pipelined.
//
//  channel   dir  fields (lowest bit up)
//  s_axis    in   tdata: begin_x[15:0] begin_y[31:16] end_x[47:32] end_y[63:48]
//  m_axis    out  tdata: angle_deg[17:0], zero pad; tuser: points_equal
//
// One request per cycle while m_axis is not stalled; the pipeline is one register
// per CORDIC iteration plus input and output stages.
// Reset clears every stage's valid bit; no clearing pass.
// A stall on m_axis freezes the whole pipeline and drops s_axis_tready.
`default_nettype none
module segment_angle_degrees (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// begin_x, begin_y, end_x, end_y
	input  wire logic [sad_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// angle_deg, then zero pad
	output logic [sad_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// points_equal
	output logic                                m_axis_tuser
);
	import sad_pkg::*;

	logic    advance;
	cordic_t prep_s1;
	cordic_t cordic_sn;

	assign advance       = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = advance;

	sad_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.in_valid (s_axis_tvalid),
		.in_data  (s_axis_tdata),
		.out_s1   (prep_s1)
	);

	sad_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.in_s1   (prep_s1),
		.out_sn  (cordic_sn)
	);

	sad_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.in_sn     (cordic_sn),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

endmodule
`default_nettype wire

// ===== rtl/core/sad_prep.sv =====
// Input stage: coordinate differences, magnitudes and quadrant flags.
`default_nettype none
module sad_prep (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         advance,
	input  wire logic                         in_valid,
	input  wire logic [sad_pkg::IN_DATA_W-1:0] in_data,
	output sad_pkg::cordic_t                  out_s1
);
	import sad_pkg::*;

	logic signed [COORD_W-1:0] bx, by, ex, ey;
	logic signed [DIFF_W-1:0]  diff_x, diff_y;
	logic [DIFF_W-1:0]         mag_x, mag_y;
	cordic_t                   nxt;

	assign bx = in_data[0*COORD_W +: COORD_W];
	assign by = in_data[1*COORD_W +: COORD_W];
	assign ex = in_data[2*COORD_W +: COORD_W];
	assign ey = in_data[3*COORD_W +: COORD_W];

	assign diff_x = DIFF_W'(ex) - DIFF_W'(bx);
	assign diff_y = DIFF_W'(ey) - DIFF_W'(by);
	assign mag_x  = diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
	assign mag_y  = diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);

	always_comb begin
		nxt               = '0;
		nxt.valid         = in_valid;
		nxt.flags.lt_x    = (bx < ex);
		nxt.flags.gt_y    = (by > ey);
		nxt.flags.dx_zero = (mag_x == '0);
		nxt.flags.dy_zero = (mag_y == '0);
		nxt.x             = XY_W'({mag_x, {GUARD_BITS{1'b0}}});
		nxt.y             = XY_W'({mag_y, {GUARD_BITS{1'b0}}});
		nxt.z             = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_s1 <= '0;
		end else if (advance) begin
			out_s1 <= nxt;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/sad_cordic.sv =====
// Unrolled vectoring CORDIC, one registered stage per iteration.
`default_nettype none
module sad_cordic (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire sad_pkg::cordic_t in_s1,
	output sad_pkg::cordic_t      out_sn
);
	import sad_pkg::*;

	function automatic cordic_t cordic_iter(input cordic_t c, input int idx);
		cordic_t                r;
		logic signed [XY_W-1:0] xs;
		logic signed [XY_W-1:0] ys;
		r  = c;
		xs = c.x >>> idx;
		ys = c.y >>> idx;
		if (!c.y[XY_W-1]) begin
			r.x = c.x + ys;
			r.y = c.y - xs;
			r.z = c.z + ATAN_Q20[idx];
		end else begin
			r.x = c.x - ys;
			r.y = c.y + xs;
			r.z = c.z - ATAN_Q20[idx];
		end
		return r;
	endfunction

	cordic_t prev   [NUM_STEPS];
	cordic_t nxt    [NUM_STEPS];
	cordic_t iter_s [NUM_STEPS];

	assign prev[0] = in_s1;

	for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
		if (i > 0) begin : g_link
			assign prev[i] = iter_s[i-1];
		end
		assign nxt[i] = cordic_iter(prev[i], i);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_STEPS; k++) begin
				iter_s[k] <= '0;
			end
		end else if (advance) begin
			for (int k = 0; k < NUM_STEPS; k++) begin
				iter_s[k] <= nxt[k];
			end
		end
	end

	assign out_sn = iter_s[NUM_STEPS-1];

endmodule
`default_nettype wire

// ===== rtl/core/sad_post.sv =====
// Output stages: clamp and round the angle, then place it by quadrant.
`default_nettype none
module sad_post (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          advance,
	input  wire sad_pkg::cordic_t              in_sn,
	output logic                               out_valid,
	output logic [sad_pkg::OUT_DATA_W-1:0]     out_data,
	output logic                               out_user
);
	import sad_pkg::*;

	logic signed [Z_W-1:0]    z_clamp;
	logic signed [Z_W-1:0]    z_round;
	logic [BASE_W-1:0]        base_nxt;
	logic                     valid_s1;
	flags_t                   flags_s1;
	logic [BASE_W-1:0]        base_s1;
	logic signed [CALC_W-1:0] base_ext;
	logic signed [CALC_W-1:0] ang;
	logic                     equal;
	logic                     valid_s2;
	logic [OUT_DATA_W-1:0]    data_s2;
	logic                     user_s2;

	always_comb begin
		priority if (in_sn.z[Z_W-1]) begin
			z_clamp = '0;
		end else if (in_sn.z > Z_FULL) begin
			z_clamp = Z_FULL;
		end else begin
			z_clamp = in_sn.z;
		end
	end

	assign z_round = z_clamp + ROUND_HALF;

	always_comb begin
		priority if (in_sn.flags.dx_zero) begin
			base_nxt = BASE_RIGHT;
		end else if (in_sn.flags.dy_zero) begin
			base_nxt = '0;
		end else begin
			base_nxt = z_round[RND_SH +: BASE_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			flags_s1 <= '0;
			base_s1  <= '0;
		end else if (advance) begin
			valid_s1 <= in_sn.valid;
			flags_s1 <= in_sn.flags;
			base_s1  <= base_nxt;
		end
	end

	assign base_ext = CALC_W'(base_s1);
	assign equal    = flags_s1.dx_zero & flags_s1.dy_zero;

	always_comb begin
		priority if (equal) begin
			ang = '0;
		end else if (flags_s1.lt_x) begin
			ang = flags_s1.gt_y ? -base_ext : base_ext;
		end else begin
			ang = flags_s1.gt_y ? base_ext - HALF_TURN : -(HALF_TURN + base_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			data_s2  <= '0;
			user_s2  <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			data_s2  <= OUT_DATA_W'(ang[ANGLE_W-1:0]);
			user_s2  <= equal;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;
	assign out_user  = user_s2;

endmodule
`default_nettype wire
